// File: rtl/vcodec_pkg.sv
// ----------------------------------------------------------------------------
// vcodec_pkg: shared types and constants of the LEB128 varint codec
// Field widths, result kinds, controller states and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package vcodec_pkg;

  localparam int VALUE_W   = 64;
  localparam int BYTE_W    = 8;
  localparam int PAY_W     = 7;
  localparam int COUNT_W   = 4;
  localparam int MAX_BYTES = 10;
  // Number of seven-bit groups needed to cover a full value.
  localparam int SLOTS     = (VALUE_W + PAY_W - 1) / PAY_W;
  localparam int SPAN_W    = SLOTS * PAY_W;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_ENC
  } state_t;

  typedef struct packed {
    logic enc_load;
    logic enc_step;
    logic dec_step;
  } cmd_t;

  typedef struct packed {
    logic in_more;
    logic sh_more;
    logic dec_emit;
  } stat_t;

endpackage

// File: rtl/varint_codec_top.sv
// ----------------------------------------------------------------------------
// varint_codec_top: 64-bit unsigned LEB128 varint encoder and decoder
// Encodes a 64-bit value into 1 to 10 bytes or decodes a byte stream back
// into values, one input beat at a time.
// ----------------------------------------------------------------------------
// In encode mode (in_mode low) one input beat carries a 64-bit value, taken
// as a raw bit pattern, and produces 1 to 10 output beats of kind byte, low
// seven bits first, with bit 7 set on every byte but the last and out_last
// high on the last. The encoder presents one byte per cycle from a shift
// register while the output slot is free; the next input beat can be
// taken at the earliest in the cycle after the final byte moves into the
// output register, in the cycle in which that byte is taken. In decode
// mode (in_mode high) each input beat carries one byte, and while the
// output slot is free the decoder takes one byte per cycle: bytes
// with bit 7 set only update the accumulator and produce no output beat, a
// byte with bit 7 clear produces one beat of kind value with the byte count,
// and a tenth byte that still has bit 7 set produces one beat of kind error
// with a zero value. Payload bits beyond bit 63 are dropped silently. An
// encode leaves a partial decode untouched, so the two may be interleaved.
// Results sit in a single output register; a new input beat is accepted
// while a finished result is taken in the same cycle, so an unstalled output
// sustains one decode byte per cycle.
// ----------------------------------------------------------------------------
module varint_codec_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_mode,
  input  logic [vcodec_pkg::VALUE_W-1:0]       in_value_in,
  input  logic [vcodec_pkg::BYTE_W-1:0]        in_byte_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_kind,
  output logic [vcodec_pkg::BYTE_W-1:0]        out_byte_out,
  output logic [vcodec_pkg::VALUE_W-1:0]       out_value_out,
  output logic [vcodec_pkg::COUNT_W-1:0]       out_byte_count,
  output logic                                 out_last
);

  // Commands from the controller and status back from the datapath.
  vcodec_pkg::cmd_t  cmd;
  vcodec_pkg::stat_t stat;

  vcodec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // The datapath holds the encode shifter, the decode accumulator and count,
  // and the output register whose fields drive the result ports directly.
  vcodec_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .value_in   (in_value_in),
    .byte_in    (in_byte_in),
    .kind       (out_kind),
    .byte_out   (out_byte_out),
    .value_out  (out_value_out),
    .byte_count (out_byte_count),
    .last       (out_last)
  );

endmodule

// File: rtl/vcodec_ctrl.sv
// ----------------------------------------------------------------------------
// vcodec_ctrl: codec controller
// Owns the handshakes and the encode sequence; tells the datapath when to
// load, shift and decode.
// ----------------------------------------------------------------------------
module vcodec_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_mode,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output vcodec_pkg::cmd_t  cmd,
  input  vcodec_pkg::stat_t stat
);

  vcodec_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;
  logic load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vcodec_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    slot_free = !out_valid_r || out_ready;
    in_ready  = 1'b0;
    cmd       = '0;
    load      = 1'b0;
    state_nxt = state_r;
    case (state_r)
      vcodec_pkg::ST_IDLE: begin
        in_ready = slot_free;
        if (in_valid && slot_free) begin
          if (!in_mode) begin
            cmd.enc_load = 1'b1;
            load         = 1'b1;
            if (stat.in_more) begin
              state_nxt = vcodec_pkg::ST_ENC;
            end
          end else begin
            cmd.dec_step = 1'b1;
            load         = stat.dec_emit;
          end
        end
      end
      vcodec_pkg::ST_ENC: begin
        if (slot_free) begin
          cmd.enc_step = 1'b1;
          load         = 1'b1;
          if (!stat.sh_more) begin
            state_nxt = vcodec_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = vcodec_pkg::ST_IDLE;
      end
    endcase
    out_valid_nxt = load || (out_valid_r && !out_ready);
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/vcodec_dp.sv
// ----------------------------------------------------------------------------
// vcodec_dp: codec datapath
// Encode shifter, decode accumulator with byte count, and the result register.
// ----------------------------------------------------------------------------
module vcodec_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  vcodec_pkg::cmd_t                     cmd,
  output vcodec_pkg::stat_t                    stat,
  input  logic [vcodec_pkg::VALUE_W-1:0]       value_in,
  input  logic [vcodec_pkg::BYTE_W-1:0]        byte_in,
  output logic [1:0]                           kind,
  output logic [vcodec_pkg::BYTE_W-1:0]        byte_out,
  output logic [vcodec_pkg::VALUE_W-1:0]       value_out,
  output logic [vcodec_pkg::COUNT_W-1:0]       byte_count,
  output logic                                 last
);

  logic [vcodec_pkg::VALUE_W-1:0] sh_r, sh_nxt;
  logic [vcodec_pkg::VALUE_W-1:0] acc_r, acc_nxt;
  logic [vcodec_pkg::COUNT_W-1:0] seen_r, seen_nxt;

  vcodec_pkg::kind_t              kind_r, kind_nxt;
  logic [vcodec_pkg::BYTE_W-1:0]  byte_r, byte_nxt;
  logic [vcodec_pkg::VALUE_W-1:0] val_r, val_nxt;
  logic [vcodec_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  logic                           last_r, last_nxt;
  logic                           out_load;

  logic [vcodec_pkg::VALUE_W-1:0] src;
  logic                           more;
  logic [vcodec_pkg::SPAN_W-1:0]  ins;
  logic [vcodec_pkg::VALUE_W-1:0] acc_new;
  logic [vcodec_pkg::COUNT_W-1:0] cnt1;
  logic                           dec_done;
  logic                           dec_err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      seen_r <= '0;
    end else begin
      acc_r  <= acc_nxt;
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
    if (out_load) begin
      kind_r <= kind_nxt;
      byte_r <= byte_nxt;
      val_r  <= val_nxt;
      cnt_r  <= cnt_nxt;
      last_r <= last_nxt;
    end
  end

  always_comb begin
    // Encode: the first byte comes straight from the input, later ones from
    // the shifter.
    src  = cmd.enc_load ? value_in : sh_r;
    more = |src[vcodec_pkg::VALUE_W-1:vcodec_pkg::PAY_W];

    // Decode: place the seven payload bits in the group picked by the count.
    ins = '0;
    for (int k = 0; k < vcodec_pkg::SLOTS; k++) begin
      if (seen_r == vcodec_pkg::COUNT_W'(k)) begin
        ins[vcodec_pkg::PAY_W*k +: vcodec_pkg::PAY_W] = byte_in[vcodec_pkg::PAY_W-1:0];
      end
    end
    acc_new  = acc_r | ins[vcodec_pkg::VALUE_W-1:0];
    cnt1     = seen_r + 1'b1;
    dec_done = !byte_in[vcodec_pkg::BYTE_W-1];
    dec_err  = byte_in[vcodec_pkg::BYTE_W-1] &&
               (cnt1 >= vcodec_pkg::COUNT_W'(vcodec_pkg::MAX_BYTES));

    stat.in_more  = |value_in[vcodec_pkg::VALUE_W-1:vcodec_pkg::PAY_W];
    stat.sh_more  = |sh_r[vcodec_pkg::VALUE_W-1:vcodec_pkg::PAY_W];
    stat.dec_emit = dec_done || dec_err;

    sh_nxt   = sh_r;
    acc_nxt  = acc_r;
    seen_nxt = seen_r;
    out_load = 1'b0;
    kind_nxt = vcodec_pkg::KIND_BYTE;
    byte_nxt = {more, src[vcodec_pkg::PAY_W-1:0]};
    val_nxt  = '0;
    cnt_nxt  = '0;
    last_nxt = !more;

    if (cmd.enc_load || cmd.enc_step) begin
      sh_nxt   = src >> vcodec_pkg::PAY_W;
      out_load = 1'b1;
    end else if (cmd.dec_step) begin
      if (dec_done) begin
        acc_nxt  = '0;
        seen_nxt = '0;
        out_load = 1'b1;
        kind_nxt = vcodec_pkg::KIND_VALUE;
        byte_nxt = '0;
        val_nxt  = acc_new;
        cnt_nxt  = cnt1;
        last_nxt = 1'b1;
      end else if (dec_err) begin
        acc_nxt  = '0;
        seen_nxt = '0;
        out_load = 1'b1;
        kind_nxt = vcodec_pkg::KIND_ERROR;
        byte_nxt = '0;
        cnt_nxt  = vcodec_pkg::COUNT_W'(vcodec_pkg::MAX_BYTES);
        last_nxt = 1'b1;
      end else begin
        acc_nxt  = acc_new;
        seen_nxt = cnt1;
      end
    end
  end

  assign kind       = kind_r;
  assign byte_out   = byte_r;
  assign value_out  = val_r;
  assign byte_count = cnt_r;
  assign last       = last_r;

endmodule

// File: rtl/vcodec_checker.sv
// ----------------------------------------------------------------------------
// vcodec_checker: port-level checks for the varint codec
// Watches the result channel and the input handshake of the top level.
// ----------------------------------------------------------------------------
module vcodec_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [1:0]                           out_kind,
  input logic [vcodec_pkg::BYTE_W-1:0]        out_byte_out,
  input logic [vcodec_pkg::VALUE_W-1:0]       out_value_out,
  input logic [vcodec_pkg::COUNT_W-1:0]       out_byte_count,
  input logic                                 out_last
);

  // A stalled result holds its beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte_out) &&
    $stable(out_value_out) && $stable(out_kind) && $stable(out_last))
    else $error("result changed while stalled");

  // An encoded byte is last exactly when its continuation bit is clear.
  a_enc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == vcodec_pkg::KIND_BYTE |->
    out_last == !out_byte_out[vcodec_pkg::BYTE_W-1])
    else $error("encode last flag disagrees with continuation bit");

  // A decoded value is a single last beat with a count in range.
  a_dec_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == vcodec_pkg::KIND_VALUE |->
    out_last && out_byte_count != '0 &&
    out_byte_count <= vcodec_pkg::COUNT_W'(vcodec_pkg::MAX_BYTES))
    else $error("decoded value with bad count");

  // An overlong decode reports a zero value and the full count.
  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == vcodec_pkg::KIND_ERROR |->
    out_last && out_value_out == '0 &&
    out_byte_count == vcodec_pkg::COUNT_W'(vcodec_pkg::MAX_BYTES))
    else $error("error beat with bad fields");

  // No new input while an encode still has bytes to send.
  a_enc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == vcodec_pkg::KIND_BYTE && !out_last |-> !in_ready)
    else $error("input taken during an unfinished encode");

endmodule

bind varint_codec_top vcodec_checker u_vcodec_checker (.*);
